FILE: design/ecsl_pkg.sv
// ---------------------------------------------------------------------------
// ecsl_pkg
// Shared types and constants of the erase-count sorted block list unit:
// command codes, fixed field widths, controller states and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ecsl_pkg;

	// fixed field widths of the ports
	localparam int CMD_W    = 3;
	localparam int BLK_W    = 10;
	localparam int ERASE_W  = 16;
	localparam int CNT_W    = 11;
	localparam int MEAN_W   = 24;
	localparam int FRAC_W   = 8;

	// block numbers are 10 bits wide, so the listed flags cover 1024 blocks
	localparam int BLK_SPACE = 1 << BLK_W;

	// command codes
	localparam logic [CMD_W-1:0] OP_ADD      = 3'd0;
	localparam logic [CMD_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [CMD_W-1:0] OP_POP_LOW  = 3'd2;
	localparam logic [CMD_W-1:0] OP_POP_HIGH = 3'd3;
	localparam logic [CMD_W-1:0] OP_QUERY    = 3'd4;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECIDE,
		ST_ADD_SCAN,
		ST_ADD_ZERO,
		ST_REM_SCAN,
		ST_DIV_LD,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller to datapath commands, at most one high per cycle
	typedef struct packed {
		logic accept;
		logic clear;
		logic decide;
		logic add_scan;
		logic add_zero;
		logic rem_scan;
		logic div_load;
		logic div_run;
		logic out_load;
	} ctrl_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic go_add;
		logic go_rem;
		logic add_stop;
		logic add_zero;
		logic rem_done;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

FILE: design/erase_count_sorted_block_list_unit.sv
// ---------------------------------------------------------------------------
// erase_count_sorted_block_list_unit
// Wear-leveling free block list kept sorted by ascending erase count, with
// add, remove, pop lowest, pop highest and membership query commands.
//
//   channel  beat fields                                   handshake
//   in       command, block_number, erase_count            in_valid / in_stall
//   out      ok, result_block, entry_count,                out_valid / out_stall
//            mean_erase_count
//
// One command at a time. Query, refused or failed commands go through
// decode, the serial divider for the mean and the result beat before the
// next beat is accepted. Add to a non-empty list, remove and the pops also
// scan the list entries through the entry memory first.
// After reset a clearing pass zeroes all 1024 listed flags; in_stall stays
// high meanwhile. A result waiting under out_stall does not block the next
// command beat from being taken.
// ---------------------------------------------------------------------------
module erase_count_sorted_block_list_unit
	import ecsl_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [BLK_W-1:0]   block_number,
	input  logic [ERASE_W-1:0] erase_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [BLK_W-1:0]   result_block,
	output logic [CNT_W-1:0]   entry_count,
	output logic [MEAN_W-1:0]  mean_erase_count
);

	ctrl_t ctrl;
	stat_t stat;

	ecsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ecsl_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.stat             (stat),
		.command          (command),
		.block_number     (block_number),
		.erase_count      (erase_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.ok               (ok),
		.result_block     (result_block),
		.entry_count      (entry_count),
		.mean_erase_count (mean_erase_count)
	);

	// accepted command keeps the input side busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while command in progress");

	// controller issues at most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctrl))
		else $error("overlapping datapath commands");

	// a new result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> !out_valid || !out_stall)
		else $error("result register overwritten");

endmodule

FILE: design/ecsl_ram.sv
// ---------------------------------------------------------------------------
// ecsl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module ecsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ecsl_ctrl.sv
// ---------------------------------------------------------------------------
// ecsl_ctrl
// Controller of the sorted block list: sequences the flag clearing pass,
// command decode, insert and remove scans, mean division and result beat.
// ---------------------------------------------------------------------------
module ecsl_ctrl
	import ecsl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		ctrl     = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				ctrl.clear = 1'b1;
				if (stat.clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.accept = 1'b1;
					state_nx    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				ctrl.decide = 1'b1;
				if (stat.go_add) begin
					state_nx = ST_ADD_SCAN;
				end else if (stat.go_rem) begin
					state_nx = ST_REM_SCAN;
				end else begin
					state_nx = ST_DIV_LD;
				end
			end
			ST_ADD_SCAN: begin
				ctrl.add_scan = 1'b1;
				if (stat.add_zero) begin
					state_nx = ST_ADD_ZERO;
				end else if (stat.add_stop) begin
					state_nx = ST_DIV_LD;
				end
			end
			ST_ADD_ZERO: begin
				ctrl.add_zero = 1'b1;
				state_nx      = ST_DIV_LD;
			end
			ST_REM_SCAN: begin
				ctrl.rem_scan = 1'b1;
				if (stat.rem_done) begin
					state_nx = ST_DIV_LD;
				end
			end
			ST_DIV_LD: begin
				ctrl.div_load = 1'b1;
				state_nx      = ST_DIV;
			end
			ST_DIV: begin
				ctrl.div_run = 1'b1;
				if (stat.div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

endmodule

FILE: design/ecsl_dp.sv
// ---------------------------------------------------------------------------
// ecsl_dp
// Datapath of the sorted block list: entry memory, listed-flag memory,
// scan pointers, running total and sum, serial divider for the mean and
// the result register.
// ---------------------------------------------------------------------------
module ecsl_dp
	import ecsl_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	output stat_t              stat,
	input  logic [CMD_W-1:0]   command,
	input  logic [BLK_W-1:0]   block_number,
	input  logic [ERASE_W-1:0] erase_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [BLK_W-1:0]   result_block,
	output logic [CNT_W-1:0]   entry_count,
	output logic [MEAN_W-1:0]  mean_erase_count
);

	localparam int IW  = $clog2(NUM_BLOCKS);
	localparam int CW  = $clog2(NUM_BLOCKS + 1);
	localparam int SW  = COUNT_BITS + CW;
	localparam int EW  = BLK_W + COUNT_BITS;
	localparam int DW  = SW + FRAC_W;
	localparam int DCW = $clog2(DW + 1);
	localparam int FAW = $clog2(BLK_SPACE);

	// command registers
	logic [CMD_W-1:0]      cmd_q;
	logic [BLK_W-1:0]      blk_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// list state
	logic [CW-1:0] total_q;
	logic [SW-1:0] sum_q;

	// scan pointers
	logic [IW-1:0] rd_idx_q, ev_idx_q, last_q;
	logic          rd_act_q, ev_vld_q, found_q, any_q;

	// result and clearing pass
	logic             ok_q;
	logic [BLK_W-1:0] res_q;
	logic [FAW-1:0]   clr_idx_q;

	// divider
	logic [CW-1:0]  rem_q;
	logic [DW-1:0]  quo_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW:0]    trial;
	logic           take;

	// memory ports
	logic                  ent_we;
	logic [IW-1:0]         ent_waddr;
	logic [EW-1:0]         ent_wdata, ent_rdata, new_entry;
	logic                  flg_we, flg_wdata, flg_rdata;
	logic [FAW-1:0]        flg_waddr;
	logic [BLK_W-1:0]      rd_block;
	logic [COUNT_BITS-1:0] rd_count;

	// decode
	logic in_range, has_room, listed, add_ok, rem_go, greater, match;

	ecsl_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS)) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (rd_idx_q),
		.rdata (ent_rdata)
	);

	ecsl_ram #(.WIDTH(1), .DEPTH(BLK_SPACE)) u_flags (
		.clk   (clk),
		.we    (flg_we),
		.waddr (flg_waddr),
		.wdata (flg_wdata),
		.raddr (FAW'(block_number)),
		.rdata (flg_rdata)
	);

	assign rd_block  = ent_rdata[EW-1:COUNT_BITS];
	assign rd_count  = ent_rdata[COUNT_BITS-1:0];
	assign new_entry = {blk_q, cnt_q};

	// command decode, flag read data belongs to the accepted block
	always_comb begin
		in_range = 32'(blk_q) < 32'(NUM_BLOCKS);
		has_room = 32'(total_q) < 32'(NUM_BLOCKS);
		listed   = in_range && flg_rdata;
		add_ok   = 1'b0;
		rem_go   = 1'b0;
		case (cmd_q)
			OP_ADD:      add_ok = in_range && !flg_rdata && has_room;
			OP_REMOVE:   rem_go = listed;
			OP_POP_LOW:  rem_go = total_q != '0;
			OP_POP_HIGH: rem_go = total_q != '0;
			default:     rem_go = 1'b0;
		endcase
	end

	// scan compares
	assign greater = rd_count > cnt_q;
	assign match   = ctrl.rem_scan && ev_vld_q && !found_q && (any_q || rd_block == blk_q);

	// entry memory write select
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = '0;
		ent_wdata = new_entry;
		if (ctrl.decide && add_ok && total_q == '0) begin
			ent_we = 1'b1;
		end else if (ctrl.add_scan && ev_vld_q) begin
			ent_we    = 1'b1;
			ent_waddr = ev_idx_q + IW'(1);
			ent_wdata = greater ? ent_rdata : new_entry;
		end else if (ctrl.add_zero) begin
			ent_we = 1'b1;
		end else if (ctrl.rem_scan && ev_vld_q && found_q) begin
			ent_we    = 1'b1;
			ent_waddr = ev_idx_q - IW'(1);
			ent_wdata = ent_rdata;
		end
	end

	// flag memory write select
	always_comb begin
		flg_we    = 1'b0;
		flg_waddr = FAW'(blk_q);
		flg_wdata = 1'b0;
		if (ctrl.clear) begin
			flg_we    = 1'b1;
			flg_waddr = clr_idx_q;
		end else if (ctrl.decide && add_ok) begin
			flg_we    = 1'b1;
			flg_wdata = 1'b1;
		end else if (match) begin
			flg_we    = 1'b1;
			flg_waddr = FAW'(rd_block);
		end
	end

	// divider trial subtract
	assign trial = {rem_q, quo_q[DW-1]};
	assign take  = trial >= {1'b0, total_q};

	// status
	always_comb begin
		stat.clr_last = clr_idx_q == FAW'(BLK_SPACE - 1);
		stat.go_add   = add_ok && total_q != '0;
		stat.go_rem   = rem_go;
		stat.add_stop = ev_vld_q && !greater;
		stat.add_zero = ev_vld_q && greater && ev_idx_q == '0;
		stat.rem_done = ev_vld_q && ev_idx_q == last_q;
		stat.div_done = dcnt_q == DCW'(1);
		stat.out_free = !out_valid || !out_stall;
	end

	// control state and list totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			sum_q     <= '0;
			clr_idx_q <= '0;
			rd_act_q  <= 1'b0;
			ev_vld_q  <= 1'b0;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				clr_idx_q <= clr_idx_q + FAW'(1);
			end
			if (ctrl.decide) begin
				rd_act_q <= stat.go_add || rem_go;
				ev_vld_q <= 1'b0;
				found_q  <= 1'b0;
				if (add_ok) begin
					total_q <= total_q + CW'(1);
					sum_q   <= sum_q + SW'(cnt_q);
				end
			end
			if (ctrl.add_scan || ctrl.rem_scan) begin
				ev_vld_q <= rd_act_q;
				if (rd_act_q && ((ctrl.add_scan && rd_idx_q == '0) ||
						(ctrl.rem_scan && rd_idx_q == last_q))) begin
					rd_act_q <= 1'b0;
				end
			end
			if (match) begin
				found_q <= 1'b1;
				total_q <= total_q - CW'(1);
				sum_q   <= sum_q - SW'(rd_count);
			end
			if (ctrl.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q <= command;
			blk_q <= block_number;
			cnt_q <= COUNT_BITS'(erase_count);
		end
		if (ctrl.decide) begin
			last_q <= IW'(total_q - CW'(1));
			any_q  <= cmd_q == OP_POP_LOW || cmd_q == OP_POP_HIGH;
			if (cmd_q == OP_POP_LOW || cmd_q == OP_REMOVE) begin
				rd_idx_q <= '0;
			end else begin
				rd_idx_q <= IW'(total_q - CW'(1));
			end
			case (cmd_q)
				OP_ADD: begin
					ok_q  <= add_ok;
					res_q <= blk_q;
				end
				OP_REMOVE: begin
					ok_q  <= 1'b0;
					res_q <= blk_q;
				end
				OP_QUERY: begin
					ok_q  <= listed;
					res_q <= blk_q;
				end
				default: begin
					ok_q  <= 1'b0;
					res_q <= '0;
				end
			endcase
		end
		// scan pointer walks down for inserts, up for removals
		if ((ctrl.add_scan || ctrl.rem_scan) && rd_act_q) begin
			ev_idx_q <= rd_idx_q;
			if (ctrl.add_scan) begin
				rd_idx_q <= rd_idx_q - IW'(1);
			end else begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
		end
		if (match) begin
			ok_q  <= 1'b1;
			res_q <= rd_block;
		end
		// restoring divider, one quotient bit per cycle
		if (ctrl.div_load) begin
			rem_q  <= '0;
			quo_q  <= {sum_q, {FRAC_W{1'b0}}};
			dcnt_q <= DCW'(DW);
		end else if (ctrl.div_run) begin
			rem_q  <= take ? CW'(trial - {1'b0, total_q}) : CW'(trial);
			quo_q  <= {quo_q[DW-2:0], take};
			dcnt_q <= dcnt_q - DCW'(1);
		end
		// result register
		if (ctrl.out_load) begin
			ok               <= ok_q;
			result_block     <= res_q;
			entry_count      <= CNT_W'(total_q);
			mean_erase_count <= (total_q == '0) ? '0 : MEAN_W'(quo_q);
		end
	end

endmodule
